FILE: rtl/core/tkeot_pkg.sv
// Package for the two-key edge order timer: request and result payload types,
// phase and colour codes, and the default tick width.
// Depends on nothing; used by every file of the block.
package tkeot_pkg;

  localparam int TICK_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH    = 32;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_FALL_K1    = 3'd1,
    PH_FALL_K2    = 3'd2,
    PH_RISE_FIRST = 3'd3,
    PH_RISE_K1    = 3'd4,
    PH_RISE_K2    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    COLOUR_GREEN  = 2'd0,
    COLOUR_RED    = 2'd1,
    COLOUR_YELLOW = 2'd2,
    COLOUR_BLUE   = 2'd3
  } colour_t;

  typedef struct packed {
    logic                   key1_fell;
    logic [FIELD_WIDTH-1:0] key1_fall_tick;
    logic                   key1_rose;
    logic [FIELD_WIDTH-1:0] key1_rise_tick;
    logic                   key2_fell;
    logic [FIELD_WIDTH-1:0] key2_fall_tick;
    logic                   key2_rose;
    logic [FIELD_WIDTH-1:0] key2_rise_tick;
  } item_t;

  typedef struct packed {
    logic [1:0]             colour_code;
    logic [FIELD_WIDTH-1:0] fall_gap;
    logic [FIELD_WIDTH-1:0] rise_gap;
    logic [FIELD_WIDTH-1:0] total_time;
  } result_t;

  typedef struct packed {
    logic    done;
    result_t data;
  } step_t;

endpackage

FILE: rtl/core/two_key_edge_order_timer.sv
// Two-key edge order timer: a request passes the request register and then the result
// register before its result is valid; a held result can stall it in between.
// One request is taken every cycle while results are drained; a held
// result stalls the request register only when the next request also completes.
// Synchronous active-high reset returns the phase to idle, clears the records and
// empties both the request register and the result register.
// Depends on tkeot_pkg and tkeot_core.
module two_key_edge_order_timer #(
  parameter int TICK_WIDTH = tkeot_pkg::TICK_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  tkeot_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_ready,
  output tkeot_pkg::result_t  result
);
  import tkeot_pkg::*;

  logic   held_valid;
  item_t  held_item;
  logic   step;
  step_t  outcome;

  tkeot_core #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (held_item),
    .outcome (outcome)
  );

  assign step       = held_valid && (!outcome.done || !result_valid || result_ready);
  assign item_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      held_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && outcome.done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && outcome.done) begin
      result <= outcome.data;
    end
  end

endmodule

FILE: rtl/core/tkeot_core.sv
// Phase machine and tick records of the two-key edge order timer.
// Updates its state when step is high and reports whether the request completes
// a measurement, with the result. Depends on tkeot_pkg.
module tkeot_core #(
  parameter int TICK_WIDTH = tkeot_pkg::TICK_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tkeot_pkg::item_t  item,
  output tkeot_pkg::step_t  outcome
);
  import tkeot_pkg::*;

  localparam int TW = TICK_WIDTH;

  phase_t        phase, phase_next;
  logic [TW-1:0] fall_one, fall_one_next;
  logic [TW-1:0] fall_two, fall_two_next;
  logic [TW-1:0] rise_one, rise_one_next;
  logic [TW-1:0] rise_two, rise_two_next;
  logic [TW-1:0] fall_gap, fall_gap_next;
  logic [TW-1:0] rise_gap, rise_gap_next;

  logic [TW-1:0] tf1, tf2, tr1, tr2;
  logic [TW-1:0] total;
  logic          done;
  logic          fall_order, rise_order;

  assign tf1 = TW'(item.key1_fall_tick);
  assign tf2 = TW'(item.key2_fall_tick);
  assign tr1 = TW'(item.key1_rise_tick);
  assign tr2 = TW'(item.key2_rise_tick);

  always_comb begin
    phase_next    = phase;
    fall_one_next = fall_one;
    fall_two_next = fall_two;
    rise_one_next = rise_one;
    rise_two_next = rise_two;
    fall_gap_next = fall_gap;
    rise_gap_next = rise_gap;
    done          = 1'b0;
    case (phase)
      PH_IDLE: begin
        fall_one_next = '0;
        fall_two_next = '0;
        rise_one_next = '0;
        rise_two_next = '0;
        fall_gap_next = '0;
        rise_gap_next = '0;
        if (item.key1_fell && item.key2_fell) begin
          fall_one_next = tf1;
          fall_two_next = tf2;
          phase_next    = PH_RISE_FIRST;
        end else if (item.key1_fell) begin
          fall_one_next = tf1;
          phase_next    = PH_FALL_K2;
        end else if (item.key2_fell) begin
          fall_two_next = tf2;
          phase_next    = PH_FALL_K1;
        end
      end
      PH_FALL_K1: begin
        if (item.key2_rose) begin
          phase_next = PH_IDLE;
        end else if (item.key1_fell) begin
          fall_one_next = tf1;
          fall_gap_next = tf1 - fall_two;
          phase_next    = PH_RISE_FIRST;
        end
      end
      PH_FALL_K2: begin
        if (item.key1_rose) begin
          phase_next = PH_IDLE;
        end else if (item.key2_fell) begin
          fall_two_next = tf2;
          fall_gap_next = tf2 - fall_one;
          phase_next    = PH_RISE_FIRST;
        end
      end
      PH_RISE_FIRST: begin
        if (item.key1_fell || item.key2_fell) begin
          phase_next = PH_IDLE;
        end else if (item.key1_rose && item.key2_rose) begin
          rise_one_next = tr1;
          rise_two_next = tr2;
          rise_gap_next = '0;
          phase_next    = PH_IDLE;
          done          = 1'b1;
        end else if (item.key1_rose) begin
          rise_one_next = tr1;
          phase_next    = PH_RISE_K2;
        end else if (item.key2_rose) begin
          rise_two_next = tr2;
          phase_next    = PH_RISE_K1;
        end
      end
      PH_RISE_K1: begin
        if (item.key2_fell) begin
          phase_next = PH_IDLE;
        end else if (item.key1_rose) begin
          rise_one_next = tr1;
          rise_gap_next = tr1 - rise_two;
          phase_next    = PH_IDLE;
          done          = 1'b1;
        end
      end
      PH_RISE_K2: begin
        if (item.key1_fell) begin
          phase_next = PH_IDLE;
        end else if (item.key2_rose) begin
          rise_two_next = tr2;
          rise_gap_next = tr2 - rise_one;
          phase_next    = PH_IDLE;
          done          = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    fall_order = fall_two_next > fall_one_next;
    rise_order = rise_two_next > rise_one_next;
    total      = fall_gap_next + rise_gap_next;
    outcome.done = done;
    if (fall_order) begin
      outcome.data.colour_code = rise_order ? COLOUR_GREEN : COLOUR_RED;
    end else begin
      outcome.data.colour_code = rise_order ? COLOUR_YELLOW : COLOUR_BLUE;
    end
    outcome.data.fall_gap   = FIELD_WIDTH'(fall_gap_next);
    outcome.data.rise_gap   = FIELD_WIDTH'(rise_gap_next);
    outcome.data.total_time = FIELD_WIDTH'(total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      fall_one <= '0;
      fall_two <= '0;
      rise_one <= '0;
      rise_two <= '0;
      fall_gap <= '0;
      rise_gap <= '0;
    end else if (step) begin
      phase    <= phase_next;
      fall_one <= fall_one_next;
      fall_two <= fall_two_next;
      rise_one <= rise_one_next;
      rise_two <= rise_two_next;
      fall_gap <= fall_gap_next;
      rise_gap <= rise_gap_next;
    end
  end

endmodule

FILE: rtl/core/tkeot_checker.sv
// Port-level checks for the two-key edge order timer, bound to the top level.
// Depends on tkeot_pkg and two_key_edge_order_timer.
module tkeot_checker #(
  parameter int TICK_WIDTH = tkeot_pkg::TICK_WIDTH_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                item_ready,
  input logic                result_valid,
  input logic                result_ready,
  input tkeot_pkg::result_t  result
);
  import tkeot_pkg::*;

  localparam logic [FIELD_WIDTH-1:0] GAP_MASK =
    (TICK_WIDTH >= FIELD_WIDTH) ? {FIELD_WIDTH{1'b1}} :
    FIELD_WIDTH'((64'd1 << TICK_WIDTH) - 64'd1);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> item_ready)
    else $error("request side not ready after reset");

  a_total_sum: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      result.total_time == ((result.fall_gap + result.rise_gap) & GAP_MASK))
    else $error("total time is not the sum of the gaps");

  a_gaps_fit: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      ((result.fall_gap & ~GAP_MASK) == '0) && ((result.rise_gap & ~GAP_MASK) == '0))
    else $error("gap wider than the tick width");

endmodule

bind two_key_edge_order_timer tkeot_checker #(
  .TICK_WIDTH(TICK_WIDTH)
) u_tkeot_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
